>>> rtl/flow_direction_packet_filter_assert.svh
// Assertion macros used by the flow direction packet filter checker.
`ifndef FLOW_DIRECTION_PACKET_FILTER_ASSERT_SVH
`define FLOW_DIRECTION_PACKET_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define FDPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define FDPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fdpf_pkg.sv
// Package: types, constants and field positions of the flow direction packet filter.
`default_nettype none
package fdpf_pkg;

  // Link header length in bytes (Ethernet without tags: 14).
  localparam int LinkHdrBytes = 14;

  // Byte positions of captured fields within the frame.
  localparam logic [15:0] PosEthHi   = 16'(LinkHdrBytes - 2);
  localparam logic [15:0] PosEthLo   = 16'(LinkHdrBytes - 1);
  localparam logic [15:0] PosIpVhl   = 16'(LinkHdrBytes);
  localparam logic [15:0] PosTotHi   = 16'(LinkHdrBytes + 2);
  localparam logic [15:0] PosTotLo   = 16'(LinkHdrBytes + 3);
  localparam logic [15:0] PosProto   = 16'(LinkHdrBytes + 9);
  localparam logic [15:0] PosSrcFrst = 16'(LinkHdrBytes + 12);
  localparam logic [15:0] PosSrcLast = 16'(LinkHdrBytes + 15);
  localparam logic [15:0] PosDstFrst = 16'(LinkHdrBytes + 16);
  localparam logic [15:0] PosDstLast = 16'(LinkHdrBytes + 19);
  localparam logic [15:0] PosTcpOff  = 16'(LinkHdrBytes + 12);
  localparam logic [15:0] PosMax     = 16'hFFFF;

  // Protocol codes and constants.
  localparam logic [15:0] EthTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp    = 8'h06;
  localparam logic [7:0]  ProtoUdp    = 8'h11;
  localparam logic [6:0]  UdpHdrBytes = 7'd8;

  // Record letters.
  localparam logic [7:0] LetterTcp = 8'h54;  // 'T'
  localparam logic [7:0] LetterUdp = 8'h55;  // 'U'
  localparam logic [7:0] LetterOut = 8'h4F;  // 'O'
  localparam logic [7:0] LetterIn  = 8'h49;  // 'I'

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] RegClientAddr = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLocalBase  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLocalPfx   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFwdClient  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFwdServer  = 3'd4;

  // Record queue depth between classifier and emitter.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // Record byte slots.
  localparam logic [1:0] SlotProto = 2'd0;
  localparam logic [1:0] SlotDir   = 2'd1;
  localparam logic [1:0] SlotLenLo = 2'd2;
  localparam logic [1:0] SlotLenHi = 2'd3;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } frame_item_t;

  typedef struct packed {
    logic [7:0] meta_byte;
    logic       meta_last;
  } meta_item_t;

  typedef struct packed {
    logic [31:0] client_address;
    logic [31:0] local_net_base;
    logic [5:0]  local_prefix_length;
    logic        forward_client_side;
    logic        forward_server_side;
  } fdpf_cfg_t;

  // One classified record waiting to be emitted.
  typedef struct packed {
    logic        is_tcp;
    logic        is_out;
    logic [15:0] pay_len;
  } fdpf_rec_t;

  // Header fields of a finished frame.
  typedef struct packed {
    logic        eth_ok;
    logic        addr_seen;
    logic        tcp_seen;
    logic [3:0]  ihw;
    logic [15:0] tot_len;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [3:0]  thw;
  } fdpf_snap_t;

endpackage
`default_nettype wire

>>> rtl/fdpf_front.sv
// Front part: capture header fields byte by byte and classify finished frames.
`default_nettype none
module fdpf_front (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire fdpf_pkg::fdpf_cfg_t   cfg_i,
  input  wire                        push_i,
  input  wire fdpf_pkg::frame_item_t in_i,
  output logic                       stall_o,
  input  wire                        q_full_i,
  output logic                       rec_valid_o,
  output fdpf_pkg::fdpf_rec_t        rec_o
);

  logic [15:0] pos_q, pos_d;
  logic [15:0] eth_q, eth_d;
  logic [3:0]  ihw_q, ihw_d;
  logic [15:0] tot_q, tot_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [3:0]  thw_q, thw_d;
  logic [15:0] tcp_pos;
  logic        accept;
  logic        snap_valid_q, snap_valid_d;
  fdpf_pkg::fdpf_snap_t snap_q, snap_d;

  assign stall_o = snap_valid_q & q_full_i;
  assign accept  = push_i & ~stall_o;
  assign tcp_pos = fdpf_pkg::PosTcpOff + {10'd0, ihw_q, 2'b00};

  // Capture the fields that the current byte belongs to.
  always_comb begin
    eth_d   = eth_q;
    ihw_d   = ihw_q;
    tot_d   = tot_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    thw_d   = thw_q;
    if (pos_q == fdpf_pkg::PosEthHi || pos_q == fdpf_pkg::PosEthLo) begin
      eth_d = {eth_q[7:0], in_i.frame_byte};
    end
    if (pos_q == fdpf_pkg::PosIpVhl) begin
      ihw_d = in_i.frame_byte[3:0];
    end
    if (pos_q == fdpf_pkg::PosTotHi || pos_q == fdpf_pkg::PosTotLo) begin
      tot_d = {tot_q[7:0], in_i.frame_byte};
    end
    if (pos_q == fdpf_pkg::PosProto) begin
      proto_d = in_i.frame_byte;
    end
    if (pos_q >= fdpf_pkg::PosSrcFrst && pos_q <= fdpf_pkg::PosSrcLast) begin
      src_d = {src_q[23:0], in_i.frame_byte};
    end
    if (pos_q >= fdpf_pkg::PosDstFrst && pos_q <= fdpf_pkg::PosDstLast) begin
      dst_d = {dst_q[23:0], in_i.frame_byte};
    end
    if (pos_q > fdpf_pkg::PosIpVhl && pos_q == tcp_pos) begin
      thw_d = in_i.frame_byte[7:4];
    end
    pos_d = (pos_q != fdpf_pkg::PosMax) ? pos_q + 16'd1 : pos_q;
  end

  // Snapshot of the frame's fields taken on its last byte.
  always_comb begin
    snap_d.eth_ok    = (eth_d == fdpf_pkg::EthTypeIpv4);
    snap_d.addr_seen = (pos_q >= fdpf_pkg::PosDstLast);
    snap_d.tcp_seen  = (pos_q >= tcp_pos);
    snap_d.ihw       = ihw_d;
    snap_d.tot_len   = tot_d;
    snap_d.proto     = proto_d;
    snap_d.src       = src_d;
    snap_d.dst       = dst_d;
    snap_d.thw       = thw_d;
  end

  // Advance capture state; clear it after the last byte of a frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      eth_q   <= '0;
      ihw_q   <= '0;
      tot_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      thw_q   <= '0;
    end else if (accept) begin
      if (in_i.frame_end) begin
        pos_q   <= '0;
        eth_q   <= '0;
        ihw_q   <= '0;
        tot_q   <= '0;
        proto_q <= '0;
        src_q   <= '0;
        dst_q   <= '0;
        thw_q   <= '0;
      end else begin
        pos_q   <= pos_d;
        eth_q   <= eth_d;
        ihw_q   <= ihw_d;
        tot_q   <= tot_d;
        proto_q <= proto_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
        thw_q   <= thw_d;
      end
    end
  end

  // Hold the snapshot until the record queue has room.
  always_comb begin
    snap_valid_d = snap_valid_q & q_full_i;
    if (accept && in_i.frame_end) begin
      snap_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else begin
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_i.frame_end) begin
      snap_q <= snap_d;
    end
  end

  // Classify the snapshot: protocol, payload length, flow direction.
  logic [5:0]  pfx_eff;
  logic [5:0]  span_sh;
  logic [31:0] span;
  logic [31:0] range_top;
  logic [6:0]  ihl_bytes;
  logic [6:0]  tcp_hdr;
  logic [6:0]  udp_hdr;
  logic [6:0]  hdr;
  logic        is_tcp, is_udp;
  logic        len_ok;
  logic        src_out, dst_out;
  logic        client_hit, server_hit;

  always_comb begin
    pfx_eff   = (cfg_i.local_prefix_length > 6'd32) ? 6'd32 : cfg_i.local_prefix_length;
    span_sh   = 6'd32 - pfx_eff;
    span      = (pfx_eff == 6'd0) ? 32'd0 : (32'd1 << span_sh[4:0]);
    range_top = cfg_i.local_net_base + span;
    src_out   = (snap_q.src < cfg_i.local_net_base) || (snap_q.src > range_top);
    dst_out   = (snap_q.dst < cfg_i.local_net_base) || (snap_q.dst > range_top);

    ihl_bytes = {1'b0, snap_q.ihw, 2'b00};
    tcp_hdr   = ihl_bytes + {1'b0, snap_q.thw, 2'b00};
    udp_hdr   = ihl_bytes + fdpf_pkg::UdpHdrBytes;
    is_tcp    = (snap_q.proto == fdpf_pkg::ProtoTcp);
    is_udp    = (snap_q.proto == fdpf_pkg::ProtoUdp);
    hdr       = is_tcp ? tcp_hdr : udp_hdr;
    if (is_tcp) begin
      len_ok = snap_q.tcp_seen && (snap_q.tot_len > {9'd0, hdr});
    end else begin
      len_ok = (snap_q.tot_len >= {9'd0, hdr});
    end

    client_hit = cfg_i.forward_client_side && (snap_q.src == cfg_i.client_address)
                 && dst_out;
    server_hit = cfg_i.forward_server_side && src_out
                 && (snap_q.dst == cfg_i.client_address);

    rec_o.is_tcp  = is_tcp;
    rec_o.is_out  = client_hit;
    rec_o.pay_len = snap_q.tot_len - {9'd0, hdr};
    rec_valid_o   = snap_valid_q && !q_full_i && snap_q.addr_seen && snap_q.eth_ok
                    && (is_tcp || is_udp) && len_ok && (client_hit || server_hit);
  end

endmodule
`default_nettype wire

>>> rtl/fdpf_queue.sv
// Record queue between the classifier and the byte emitter.
`default_nettype none
module fdpf_queue (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      wr_i,
  input  wire fdpf_pkg::fdpf_rec_t wr_rec_i,
  output logic                     full_o,
  input  wire                      rd_i,
  output fdpf_pkg::fdpf_rec_t      rd_rec_o,
  output logic                     empty_o
);

  fdpf_pkg::fdpf_rec_t         mem_q [fdpf_pkg::QDepth];
  logic [fdpf_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [fdpf_pkg::QPtrW:0]    cnt_q;
  logic                        do_wr, do_rd;

  assign full_o   = (cnt_q == (fdpf_pkg::QPtrW+1)'(fdpf_pkg::QDepth));
  assign empty_o  = (cnt_q == '0);
  assign do_wr    = wr_i & ~full_o;
  assign do_rd    = rd_i & ~empty_o;
  assign rd_rec_o = mem_q[rd_ptr_q];

  // Advance pointers and the fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_wr && do_rd) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store records.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_rec_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/fdpf_back.sv
// Back part: emit each queued record as four bytes.
`default_nettype none
module fdpf_back (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire fdpf_pkg::fdpf_rec_t rec_i,
  input  wire                      q_empty_i,
  output logic                     q_rd_o,
  input  wire                      pop_i,
  output logic                     empty_o,
  output fdpf_pkg::meta_item_t     out_o
);

  logic [1:0] slot_q;
  logic       take;

  assign empty_o = q_empty_i;
  assign take    = pop_i & ~q_empty_i;
  assign q_rd_o  = take & (slot_q == fdpf_pkg::SlotLenHi);

  // Select the byte of the current slot.
  always_comb begin
    case (slot_q)
      fdpf_pkg::SlotProto: out_o.meta_byte = rec_i.is_tcp ? fdpf_pkg::LetterTcp
                                                          : fdpf_pkg::LetterUdp;
      fdpf_pkg::SlotDir:   out_o.meta_byte = rec_i.is_out ? fdpf_pkg::LetterOut
                                                          : fdpf_pkg::LetterIn;
      fdpf_pkg::SlotLenLo: out_o.meta_byte = rec_i.pay_len[7:0];
      fdpf_pkg::SlotLenHi: out_o.meta_byte = rec_i.pay_len[15:8];
      default:             out_o.meta_byte = '0;
    endcase
    out_o.meta_last = (slot_q == fdpf_pkg::SlotLenHi);
  end

  // Advance the slot on each request taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= fdpf_pkg::SlotProto;
    end else if (take) begin
      slot_q <= slot_q + 2'd1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/flow_direction_packet_filter.sv
// Top level: configuration registers, front classifier, record queue, byte emitter.
// Takes one frame byte per cycle with no gaps while the record queue has room.
// A matching frame's snapshot is registered, then queued, before its bytes show.
// One record byte per cycle on pop when not empty; a matching frame yields four.
// The front stalls only when a finished frame waits on a full four-entry queue.
// Reset clears capture state and queue; registers take 0, 0, 16, 1, 0.
`default_nettype none
module flow_direction_packet_filter (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                push,
  output logic                               full,
  input  wire fdpf_pkg::frame_item_t         in_i,
  input  wire                                pop,
  output logic                               empty,
  output fdpf_pkg::meta_item_t               out_o,
  input  wire                                cfg_we_i,
  input  wire [fdpf_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire [fdpf_pkg::CfgDataW-1:0]       cfg_wdata_i
);

  fdpf_pkg::fdpf_cfg_t cfg_q;
  fdpf_pkg::fdpf_rec_t wr_rec, rd_rec;
  logic                rec_valid;
  logic                q_full, q_empty, q_rd;

  // Write configuration registers; ignore unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.client_address      <= 32'd0;
      cfg_q.local_net_base      <= 32'd0;
      cfg_q.local_prefix_length <= 6'd16;
      cfg_q.forward_client_side <= 1'b1;
      cfg_q.forward_server_side <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fdpf_pkg::RegClientAddr: cfg_q.client_address      <= cfg_wdata_i;
        fdpf_pkg::RegLocalBase:  cfg_q.local_net_base      <= cfg_wdata_i;
        fdpf_pkg::RegLocalPfx:   cfg_q.local_prefix_length <= cfg_wdata_i[5:0];
        fdpf_pkg::RegFwdClient:  cfg_q.forward_client_side <= cfg_wdata_i[0];
        fdpf_pkg::RegFwdServer:  cfg_q.forward_server_side <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  fdpf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .in_i        (in_i),
    .stall_o     (full),
    .q_full_i    (q_full),
    .rec_valid_o (rec_valid),
    .rec_o       (wr_rec)
  );

  fdpf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (rec_valid),
    .wr_rec_i (wr_rec),
    .full_o   (q_full),
    .rd_i     (q_rd),
    .rd_rec_o (rd_rec),
    .empty_o  (q_empty)
  );

  fdpf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rec_i     (rd_rec),
    .q_empty_i (q_empty),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_o     (out_o)
  );

endmodule
`default_nettype wire

>>> rtl/fdpf_checker.sv
// Port checker for the flow direction packet filter, bound to the top level.
`default_nettype none
`include "flow_direction_packet_filter_assert.svh"
module fdpf_checker (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       pop,
  input wire                       empty,
  input wire fdpf_pkg::meta_item_t out_o
);

  logic [1:0] slot_q;
  logic       waiting;
  logic       at_proto, at_dir;
  logic       last_ok, proto_ok, dir_ok;

  // Track the record byte slot from taken requests.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= fdpf_pkg::SlotProto;
    end else if (pop && !empty) begin
      slot_q <= slot_q + 2'd1;
    end
  end

  // Decode what the current slot allows.
  assign waiting  = !empty && !pop;
  assign at_proto = !empty && (slot_q == fdpf_pkg::SlotProto);
  assign at_dir   = !empty && (slot_q == fdpf_pkg::SlotDir);
  assign last_ok  = out_o.meta_last == (slot_q == fdpf_pkg::SlotLenHi);
  assign proto_ok = (out_o.meta_byte == fdpf_pkg::LetterTcp)
                    || (out_o.meta_byte == fdpf_pkg::LetterUdp);
  assign dir_ok   = (out_o.meta_byte == fdpf_pkg::LetterOut)
                    || (out_o.meta_byte == fdpf_pkg::LetterIn);

  `FDPF_ASSERT_NEXT(a_out_hold, waiting, !empty && $stable(out_o), "result changed while waiting")
  `FDPF_ASSERT_NOW(a_last_slot, !empty, last_ok, "meta_last off the fourth byte")
  `FDPF_ASSERT_NOW(a_proto_letter, at_proto, proto_ok, "bad protocol letter")
  `FDPF_ASSERT_NOW(a_dir_letter, at_dir, dir_ok, "bad direction letter")

endmodule

bind flow_direction_packet_filter fdpf_checker u_fdpf_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .pop    (pop),
  .empty  (empty),
  .out_o  (out_o)
);
`default_nettype wire
